FILE: hdl/tlvf_pkg.sv
// shared types, register map and character codes of the text line view filter
`timescale 1ns / 1ps

package tlvf_pkg;

  localparam int NUMBER_DIGITS_DEFAULT = 6;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_INDEX_W = 3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_ALL      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_NONBLANK = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SQUEEZE_EMPTY   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_LINE_ENDS  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_TAB_MARKS  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_NONPRINT   = 3'd5;

  // character codes
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NEWLINE  = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_LETTER_I = 8'h49;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_DELETE   = 8'h7F;
  localparam logic [7:0] CH_CTRL_MAX = 8'h1F;
  localparam logic [7:0] CH_HIGH_MIN = 8'h80;
  localparam logic [7:0] CARET_OFFSET = 8'd64;

  localparam logic [3:0] DIGIT_NINE = 4'd9;
  localparam logic [1:0] EMPTY_RUN_MAX = 2'd2;

  typedef struct packed {
    logic number_all_lines;
    logic number_nonblank_lines;
    logic squeeze_empty;
    logic show_line_ends;
    logic show_tab_marks;
    logic show_nonprinting;
  } tlvf_cfg_t;

endpackage

FILE: hdl/tlvf_in_if.sv
// input byte channel
`timescale 1ns / 1ps

interface tlvf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

FILE: hdl/tlvf_out_if.sv
// output byte channel
`timescale 1ns / 1ps

interface tlvf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

FILE: hdl/tlvf_regs.sv
// apb configuration registers
`timescale 1ns / 1ps

module tlvf_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tlvf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tlvf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tlvf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output tlvf_pkg::tlvf_cfg_t            cfg
);
  import tlvf_pkg::*;

  logic [CFG_INDEX_W-1:0] reg_index;
  logic                   wr_en;
  logic                   rd_bit;

  assign reg_index = paddr[CFG_ADDR_W-1:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_index)
        REG_NUMBER_ALL:      cfg.number_all_lines      <= pwdata[0];
        REG_NUMBER_NONBLANK: cfg.number_nonblank_lines <= pwdata[0];
        REG_SQUEEZE_EMPTY:   cfg.squeeze_empty         <= pwdata[0];
        REG_SHOW_LINE_ENDS:  cfg.show_line_ends        <= pwdata[0];
        REG_SHOW_TAB_MARKS:  cfg.show_tab_marks        <= pwdata[0];
        REG_SHOW_NONPRINT:   cfg.show_nonprinting      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_NUMBER_ALL:      rd_bit = cfg.number_all_lines;
      REG_NUMBER_NONBLANK: rd_bit = cfg.number_nonblank_lines;
      REG_SQUEEZE_EMPTY:   rd_bit = cfg.squeeze_empty;
      REG_SHOW_LINE_ENDS:  rd_bit = cfg.show_line_ends;
      REG_SHOW_TAB_MARKS:  rd_bit = cfg.show_tab_marks;
      REG_SHOW_NONPRINT:   rd_bit = cfg.show_nonprinting;
      default:             rd_bit = 1'b0;
    endcase
  end

  assign prdata = {{(CFG_DATA_W-1){1'b0}}, rd_bit};

endmodule

FILE: hdl/tlvf_expand.sv
// input register, line state and expansion of one byte into its output run
`timescale 1ns / 1ps

module tlvf_expand #(
  parameter int NUMBER_DIGITS = tlvf_pkg::NUMBER_DIGITS_DEFAULT,
  parameter int RUN_MAX       = NUMBER_DIGITS + 3,
  parameter int CNT_W         = $clog2(RUN_MAX + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  tlvf_pkg::tlvf_cfg_t cfg,
  tlvf_in_if.sink             bytes_in,
  output logic                exp_valid,
  input  logic                exp_ready,
  output logic [7:0]          exp_bytes [RUN_MAX],
  output logic [CNT_W-1:0]    exp_count
);
  import tlvf_pkg::*;

  localparam int BCD_W = 4 * NUMBER_DIGITS;

  // input register
  logic       held_valid;
  logic [7:0] held_byte;

  // line state
  logic             at_line_start;
  logic [1:0]       empty_run;
  logic [BCD_W-1:0] line_number;

  logic             at_line_start_next;
  logic [1:0]       empty_run_next;
  logic [BCD_W-1:0] line_number_next;

  logic             advance;
  logic             is_newline;
  logic             squeezed;
  logic             numbered;
  logic [7:0]       body0;
  logic [7:0]       body1;
  logic             body_two;
  logic [BCD_W-1:0] bumped;
  logic             carry;
  logic [3:0]       digit;
  logic [7:0]       num_chars [NUMBER_DIGITS];

  always_comb begin
    is_newline = (held_byte == CH_NEWLINE);

    // empty line bookkeeping, only at a line start
    empty_run_next = empty_run;
    if (at_line_start) begin
      if (!is_newline) begin
        empty_run_next = '0;
      end else if (empty_run < EMPTY_RUN_MAX) begin
        empty_run_next = empty_run + 2'd1;
      end
    end
    squeezed = at_line_start && cfg.squeeze_empty && (empty_run_next == EMPTY_RUN_MAX);
    numbered = at_line_start && !squeezed &&
               ((cfg.number_nonblank_lines && !is_newline) || cfg.number_all_lines);
    at_line_start_next = squeezed ? at_line_start : is_newline;

    // counter increment with saturation at all nines
    bumped = line_number;
    carry  = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      digit = line_number[4*i +: 4];
      if (carry) begin
        bumped[4*i +: 4] = (digit == DIGIT_NINE) ? 4'd0 : digit + 4'd1;
      end
      carry = carry && (digit == DIGIT_NINE);
    end
    line_number_next = (numbered && !carry) ? bumped : line_number;

    // number text, most significant digit first, leading zeros blank
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      if ((NUMBER_DIGITS - 1 - k) > 0 &&
          (line_number >> (4 * (NUMBER_DIGITS - 1 - k))) == '0) begin
        num_chars[k] = CH_SPACE;
      end else begin
        num_chars[k] = CH_ZERO + {4'd0, line_number[4*(NUMBER_DIGITS-1-k) +: 4]};
      end
    end

    // body of one or two bytes
    body0    = held_byte;
    body1    = held_byte;
    body_two = 1'b0;
    if (cfg.show_tab_marks && held_byte == CH_TAB) begin
      body0    = CH_CARET;
      body1    = CH_LETTER_I;
      body_two = 1'b1;
    end else if (cfg.show_line_ends && is_newline) begin
      body0    = CH_DOLLAR;
      body_two = 1'b1;
    end else if (cfg.show_nonprinting && !is_newline && held_byte != CH_TAB) begin
      if (held_byte <= CH_CTRL_MAX || held_byte >= CH_HIGH_MIN) begin
        body0    = CH_CARET;
        body1    = held_byte + CARET_OFFSET;
        body_two = 1'b1;
      end else if (held_byte == CH_DELETE) begin
        body0    = CH_CARET;
        body1    = CH_QUESTION;
        body_two = 1'b1;
      end
    end

    // assemble the run
    for (int j = 0; j < RUN_MAX; j++) begin
      exp_bytes[j] = '0;
    end
    if (numbered) begin
      for (int k = 0; k < NUMBER_DIGITS; k++) begin
        exp_bytes[k] = num_chars[k];
      end
      exp_bytes[NUMBER_DIGITS]     = CH_TAB;
      exp_bytes[NUMBER_DIGITS + 1] = body_two ? body0 : body1;
      exp_bytes[NUMBER_DIGITS + 2] = body1;
    end else begin
      exp_bytes[0] = body_two ? body0 : body1;
      exp_bytes[1] = body1;
    end

    if (squeezed) begin
      exp_count = '0;
    end else begin
      exp_count = (numbered ? CNT_W'(NUMBER_DIGITS + 1) : '0) +
                  (body_two ? CNT_W'(2) : CNT_W'(1));
    end
  end

  assign exp_valid        = held_valid && !squeezed;
  assign advance          = held_valid && (squeezed || exp_ready);
  assign bytes_in.ready   = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid    <= 1'b0;
      at_line_start <= 1'b1;
      empty_run     <= '0;
      line_number   <= BCD_W'(1);
    end else begin
      if (bytes_in.ready) begin
        held_valid <= bytes_in.valid;
      end
      if (advance) begin
        at_line_start <= at_line_start_next;
        empty_run     <= empty_run_next;
        line_number   <= line_number_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bytes_in.valid && bytes_in.ready) begin
      held_byte <= bytes_in.in_byte;
    end
  end

endmodule

FILE: hdl/tlvf_drain.sv
// result register holding one output run and sending it out byte by byte
`timescale 1ns / 1ps

module tlvf_drain #(
  parameter int NUMBER_DIGITS = tlvf_pkg::NUMBER_DIGITS_DEFAULT,
  parameter int RUN_MAX       = NUMBER_DIGITS + 3,
  parameter int CNT_W         = $clog2(RUN_MAX + 1),
  parameter int IDX_W         = $clog2(RUN_MAX)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             exp_valid,
  output logic             exp_ready,
  input  logic [7:0]       exp_bytes [RUN_MAX],
  input  logic [CNT_W-1:0] exp_count,
  tlvf_out_if.source       bytes_out
);

  logic [7:0]       run_bytes [RUN_MAX];
  logic [CNT_W-1:0] run_last;
  logic [IDX_W-1:0] idx;
  logic             run_valid;
  logic             at_last;
  logic             take;
  logic             load;

  assign at_last   = (CNT_W'(idx) == run_last);
  assign take      = run_valid && bytes_out.ready;
  assign exp_ready = !run_valid || (take && at_last);
  assign load      = exp_valid && exp_ready;

  assign bytes_out.valid       = run_valid;
  assign bytes_out.out_byte    = run_bytes[idx];
  assign bytes_out.last_of_run = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      run_valid <= 1'b1;
      idx       <= '0;
    end else if (take) begin
      if (at_last) begin
        run_valid <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_bytes <= exp_bytes;
      run_last  <= exp_count - CNT_W'(1);
    end
  end

endmodule

FILE: hdl/text_line_view_filter_core.sv
// top level of the text line view filter
`timescale 1ns / 1ps

// byte stream text filter with line numbering and visible-character modes.
// each input item is one byte; it yields zero to NUMBER_DIGITS+3 output items,
// the last of which carries last_of_run. an accepted byte is held in the
// input register, is expanded by short logic into a whole run (number
// prefix, tab, one or two body bytes) that is loaded into the result
// register, and the run then leaves one byte per cycle while the output is
// ready. a byte that expands to a single output item therefore sustains one
// item per cycle; a byte that expands to more holds later input back until
// its last byte is taken, as there is a single output byte lane. a squeezed
// empty line produces no output and passes without waiting for the output.
// registers (apb, byte address 4*index, bit 0 only): 0 number all lines,
// 1 number non-empty lines, 2 squeeze empty lines, 3 show line ends,
// 4 show tab marks, 5 show nonprinting. write them only while idle.
// the line counter is bcd and holds at all nines.

module text_line_view_filter_core #(
  parameter int NUMBER_DIGITS = tlvf_pkg::NUMBER_DIGITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tlvf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tlvf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tlvf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  tlvf_in_if.sink                         bytes_in,
  tlvf_out_if.source                      bytes_out
);
  import tlvf_pkg::*;

  // longest run: number digits, tab and two body bytes
  localparam int RUN_MAX = NUMBER_DIGITS + 3;
  localparam int CNT_W   = $clog2(RUN_MAX + 1);
  localparam int IDX_W   = $clog2(RUN_MAX);

  tlvf_cfg_t        cfg;
  logic             exp_valid;
  logic             exp_ready;
  logic [7:0]       exp_bytes [RUN_MAX];
  logic [CNT_W-1:0] exp_count;

  // configuration registers
  tlvf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register, line state and run assembly
  tlvf_expand #(
    .NUMBER_DIGITS (NUMBER_DIGITS),
    .RUN_MAX       (RUN_MAX),
    .CNT_W         (CNT_W)
  ) u_expand (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .bytes_in  (bytes_in),
    .exp_valid (exp_valid),
    .exp_ready (exp_ready),
    .exp_bytes (exp_bytes),
    .exp_count (exp_count)
  );

  // result register and byte serializer
  tlvf_drain #(
    .NUMBER_DIGITS (NUMBER_DIGITS),
    .RUN_MAX       (RUN_MAX),
    .CNT_W         (CNT_W),
    .IDX_W         (IDX_W)
  ) u_drain (
    .clk       (clk),
    .rst       (rst),
    .exp_valid (exp_valid),
    .exp_ready (exp_ready),
    .exp_bytes (exp_bytes),
    .exp_count (exp_count),
    .bytes_out (bytes_out)
  );

endmodule
